>>> rtl/overlap_box_grouping_defines.svh
// ----------------------------------------------------------------------------
// Overlap box grouping: assertion macros
// Shared property macros for the concurrent checks of the grouping block.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_BOX_GROUPING_DEFINES_SVH
`define OVERLAP_BOX_GROUPING_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define OVB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define OVB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ovb_pkg.sv
// ----------------------------------------------------------------------------
// Overlap box grouping package
// Box type, padding constants, register codes and box helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ovb_pkg;

    localparam int DEF_MAX_BOXES = 64;
    localparam int IDX_OUT_W     = 6;
    localparam int CFG_W         = 13;

    localparam logic [11:0] PAD_LEFT  = 12'd20;
    localparam logic [11:0] PAD_UP    = 12'd50;
    localparam logic [13:0] PAD_WIDER = 14'd20;
    localparam logic [13:0] PAD_TALL  = 14'd80;

    localparam logic [CFG_W-1:0] IMG_W_RST = 13'd1920;
    localparam logic [CFG_W-1:0] IMG_H_RST = 13'd1080;

    typedef enum logic [0:0] {
        REG_IMG_W = 1'b0,
        REG_IMG_H = 1'b1
    } t_reg_idx;

    // Padded box: width and height keep the carry past 13 bits
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [13:0] w;
        logic [13:0] h;
    } t_box;

    // Pad one edge/extent pair and clip the extent to the image size
    function automatic logic [25:0] pad_axis(logic [11:0] pos, logic [12:0] len,
                                             logic [11:0] pad, logic [13:0] grow,
                                             logic [CFG_W-1:0] lim);
        logic [11:0] p;
        logic [13:0] l;
        logic [14:0] e;
        p = (pos > pad) ? pos - pad : 12'd0;
        l = {1'b0, len} + grow;
        e = {3'b000, p} + {1'b0, l};
        if (e > {2'b00, lim}) begin
            l = (lim > {1'b0, p}) ? {1'b0, lim - {1'b0, p}} : 14'd0;
        end
        return {p, l};
    endfunction

    // Overlap of two boxes, each shrunk by one pixel, along one axis
    function automatic logic axis_touch(logic [11:0] a, logic [13:0] al,
                                        logic [11:0] b, logic [13:0] bl);
        logic [14:0] ae;
        logic [14:0] be;
        logic [14:0] mn;
        logic [14:0] mx;
        ae = {3'b000, a} + {1'b0, al};
        be = {3'b000, b} + {1'b0, bl};
        mn = (ae < be) ? ae : be;
        mx = (a > b) ? {3'b000, a} : {3'b000, b};
        return mn > (mx + 15'd1);
    endfunction

endpackage

>>> rtl/ovb_cell.sv
// ----------------------------------------------------------------------------
// Overlap box grouping cell
// Holds one stored box with its index, label and pending flag; takes its
// neighbor's contents on every advance and tests its box against the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ovb_cell #(
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_clear,
    input  logic             i_merge,
    input  logic             i_nxt_valid,
    input  logic             i_nxt_pend,
    input  logic [IDX_W-1:0] i_nxt_idx,
    input  logic [IDX_W-1:0] i_nxt_lab,
    input  ovb_pkg::t_box    i_nxt_box,
    input  logic             i_head_valid,
    input  logic [IDX_W-1:0] i_head_idx,
    input  logic [IDX_W-1:0] i_head_lab,
    input  ovb_pkg::t_box    i_head_box,
    input  logic [IDX_W-1:0] i_root,
    output logic             o_valid,
    output logic             o_pend,
    output logic [IDX_W-1:0] o_idx,
    output logic [IDX_W-1:0] o_fwd_lab,
    output ovb_pkg::t_box    o_box,
    output logic             o_match,
    output logic             o_before
);
    import ovb_pkg::*;

    logic             r_valid;
    logic             r_pend;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_lab;
    t_box             r_box;
    logic             w_join;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_nxt_valid;
            r_pend  <= i_nxt_pend;
        end
    end

    // Payload advances with the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_idx <= i_nxt_idx;
            r_lab <= i_nxt_lab;
            r_box <= i_nxt_box;
        end
    end

    // Take the head label when a later box overlaps the head box
    assign w_join = i_merge && i_head_valid && r_valid && (r_idx > i_head_idx)
                 && axis_touch(r_box.x, r_box.w, i_head_box.x, i_head_box.w)
                 && axis_touch(r_box.y, r_box.h, i_head_box.y, i_head_box.h);

    assign o_valid   = r_valid;
    assign o_pend    = r_pend;
    assign o_idx     = r_idx;
    assign o_box     = r_box;
    assign o_fwd_lab = w_join ? i_head_lab : r_lab;
    assign o_match   = r_valid && r_pend && (r_lab == i_root);
    assign o_before  = r_valid && r_pend && (r_idx < i_head_idx);

endmodule

>>> rtl/overlap_box_grouping.sv
// ----------------------------------------------------------------------------
// Overlap box grouping
// Stores padded detection boxes in a ring of cells, labels overlapping boxes
// on the final box and returns every box grouped by label.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    box_x, box_y, box_w, box_h, final_box
//  out       output     o_out_valid / i_out_ready  box_index .. run_end
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  A box that is not final is stored and the next can follow straight after.
//  A final box starts a grouping sweep, one rotation of the cell ring. Each
//  group is then found and read out by rotating the ring; a result is
//  registered as its box passes the head. The input waits until the last
//  result is registered; a stalled output holds the ring. Reset is
//  synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module overlap_box_grouping #(
    parameter int MAX_BOXES = ovb_pkg::DEF_MAX_BOXES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [11:0]              i_box_x,
    input  logic [11:0]              i_box_y,
    input  logic [12:0]              i_box_w,
    input  logic [12:0]              i_box_h,
    input  logic                     i_final_box,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [5:0]               o_box_index,
    output logic [5:0]               o_group_index,
    output logic [11:0]              o_out_x,
    output logic [11:0]              o_out_y,
    output logic [12:0]              o_out_w,
    output logic [12:0]              o_out_h,
    output logic                     o_group_end,
    output logic                     o_run_end,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [0:0]               i_cfg_index,
    input  logic [ovb_pkg::CFG_W-1:0] i_cfg_data
);
    import ovb_pkg::*;

    `include "overlap_box_grouping_defines.svh"

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_MERGE,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_rot;
    logic [IW-1:0]    r_root;
    logic             r_have_root;
    logic [IW-1:0]    r_grp;
    logic [CFG_W-1:0] r_img_w;
    logic [CFG_W-1:0] r_img_h;
    logic             r_out_valid;

    logic             w_valid [MAX_BOXES];
    logic             w_pend  [MAX_BOXES];
    logic [IW-1:0]    w_idx   [MAX_BOXES];
    logic [IW-1:0]    w_lab   [MAX_BOXES];
    t_box             w_box   [MAX_BOXES];
    logic [MAX_BOXES-1:0] w_match;
    logic [MAX_BOXES-1:0] w_before;
    logic [MAX_BOXES-1:0] w_busy;

    logic             w_in_acc;
    logic             w_store;
    logic             w_shift;
    logic             w_clear;
    logic             w_merge;
    logic             w_tail_valid;
    logic             w_tail_pend;
    logic [IW-1:0]    w_tail_idx;
    logic [IW-1:0]    w_tail_lab;
    t_box             w_tail_box;
    t_box             w_pad;
    logic [25:0]      w_pad_x;
    logic [25:0]      w_pad_y;
    logic             w_hp;
    logic             w_start;
    logic             w_want;
    logic             w_out_free;
    logic             w_emit;
    logic [IW-1:0]    w_sel_root;
    logic             w_grp_end;
    logic             w_run_end;

    // Pad the incoming box and clip it to the image
    assign w_pad_x = pad_axis(i_box_x, i_box_w, PAD_LEFT, PAD_WIDER, r_img_w);
    assign w_pad_y = pad_axis(i_box_y, i_box_h, PAD_UP, PAD_TALL, r_img_h);
    assign w_pad   = '{x: w_pad_x[25:14], y: w_pad_y[25:14],
                       w: w_pad_x[13:0], h: w_pad_y[13:0]};

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_store     = w_in_acc && (r_count < CW'(MAX_BOXES));

    // Readout selection at the head of the ring
    assign w_hp       = w_valid[0] && w_pend[0];
    assign w_start    = !r_have_root && w_hp && !(|w_before);
    assign w_sel_root = r_have_root ? r_root : w_idx[0];
    assign w_want     = w_hp && (w_start || (r_have_root && (w_lab[0] == r_root)));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == S_EMIT) && w_want && w_out_free;
    assign w_grp_end  = !(|w_match[MAX_BOXES-1:1]);
    assign w_run_end  = !(|w_busy[MAX_BOXES-1:1]);

    // Chain control
    assign w_merge = (r_state == S_MERGE);
    assign w_clear = w_emit && w_run_end;
    always_comb begin
        case (r_state)
            S_LOAD:  w_shift = w_store;
            S_MERGE: w_shift = 1'b1;
            S_EMIT:  w_shift = !(w_want && !w_out_free);
            default: w_shift = 1'b0;
        endcase
    end

    // Tail input: new box while loading, head wraps around otherwise
    always_comb begin
        if (r_state == S_LOAD) begin
            w_tail_valid = 1'b1;
            w_tail_pend  = 1'b1;
            w_tail_idx   = r_count[IW-1:0];
            w_tail_lab   = r_count[IW-1:0];
            w_tail_box   = w_pad;
        end else begin
            w_tail_valid = w_valid[0];
            w_tail_pend  = w_pend[0] && !w_emit;
            w_tail_idx   = w_idx[0];
            w_tail_lab   = w_lab[0];
            w_tail_box   = w_box[0];
        end
    end

    // Ring of cells
    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        logic             w_nv;
        logic             w_np;
        logic [IW-1:0]    w_ni;
        logic [IW-1:0]    w_nl;
        t_box             w_nb;
        if (k == MAX_BOXES - 1) begin : g_tail
            assign w_nv = w_tail_valid;
            assign w_np = w_tail_pend;
            assign w_ni = w_tail_idx;
            assign w_nl = w_tail_lab;
            assign w_nb = w_tail_box;
        end else begin : g_body
            assign w_nv = w_valid[k+1];
            assign w_np = w_pend[k+1];
            assign w_ni = w_idx[k+1];
            assign w_nl = w_lab[k+1];
            assign w_nb = w_box[k+1];
        end
        ovb_cell #(.IDX_W(IW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_shift),
            .i_clear      (w_clear),
            .i_merge      (w_merge),
            .i_nxt_valid  (w_nv),
            .i_nxt_pend   (w_np),
            .i_nxt_idx    (w_ni),
            .i_nxt_lab    (w_nl),
            .i_nxt_box    (w_nb),
            .i_head_valid (w_valid[0]),
            .i_head_idx   (w_idx[0]),
            .i_head_lab   (w_lab[0]),
            .i_head_box   (w_box[0]),
            .i_root       (w_sel_root),
            .o_valid      (w_valid[k]),
            .o_pend       (w_pend[k]),
            .o_idx        (w_idx[k]),
            .o_fwd_lab    (w_lab[k]),
            .o_box        (w_box[k]),
            .o_match      (w_match[k]),
            .o_before     (w_before[k])
        );
        assign w_busy[k] = w_valid[k] && w_pend[k];
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_rot       <= '0;
            r_root      <= '0;
            r_have_root <= 1'b0;
            r_grp       <= '0;
            r_img_w     <= IMG_W_RST;
            r_img_h     <= IMG_H_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_IMG_W: r_img_w <= i_cfg_data;
                    REG_IMG_H: r_img_h <= i_cfg_data;
                    default:   r_img_w <= r_img_w;
                endcase
            end
            if (w_emit) begin
                r_out_valid   <= 1'b1;
                o_box_index   <= IDX_OUT_W'(w_idx[0]);
                o_group_index <= IDX_OUT_W'(r_grp);
                o_out_x       <= w_box[0].x;
                o_out_y       <= w_box[0].y;
                o_out_w       <= w_box[0].w[12:0];
                o_out_h       <= w_box[0].h[12:0];
                o_group_end   <= w_grp_end;
                o_run_end     <= w_run_end;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_store) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (w_in_acc && i_final_box) begin
                        r_state <= S_MERGE;
                        r_rot   <= '0;
                    end
                end
                S_MERGE: begin
                    r_rot <= r_rot + CW'(1);
                    if (r_rot == CW'(MAX_BOXES - 1)) begin
                        r_state     <= S_EMIT;
                        r_have_root <= 1'b0;
                        r_grp       <= '0;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_root      <= w_sel_root;
                        r_have_root <= !w_grp_end;
                        if (w_grp_end) begin
                            r_grp <= r_grp + IW'(1);
                        end
                        if (w_run_end) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    `OVB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_BOXES), "box count past capacity")
    `OVB_ASSERT_NOW(a_run_end_group, i_clk, i_rst_n, o_out_valid && o_run_end, o_group_end, "run end not closing a group")
    `OVB_ASSERT_NOW(a_load_no_root, i_clk, i_rst_n, o_in_ready, !r_have_root, "open group while loading")
    `OVB_ASSERT_NEXT(a_final_merge, i_clk, i_rst_n, w_in_acc && i_final_box, r_state == S_MERGE, "final box did not start grouping")

endmodule

>>> dv/overlap_box_grouping_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap box grouping testbench
// Drives frames of detection boxes with random idling on both channels,
// predicts the padded, clipped and grouped results of each frame, and
// compares every returned box field by field in arrival order.
// ----------------------------------------------------------------------------
module overlap_box_grouping_tb;
    import ovb_pkg::*;

    localparam int CAPACITY = DEF_MAX_BOXES;

    typedef struct {
        bit [11:0] x;
        bit [11:0] y;
        bit [13:0] w;
        bit [13:0] h;
    } t_stored_box;

    typedef struct {
        bit [5:0]  box_index;
        bit [5:0]  group_index;
        bit [11:0] x;
        bit [11:0] y;
        bit [12:0] w;
        bit [12:0] h;
        bit        group_end;
        bit        run_end;
    } t_grouped_box;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [11:0] i_box_x;
    logic [11:0] i_box_y;
    logic [12:0] i_box_w;
    logic [12:0] i_box_h;
    logic        i_final_box;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_box_index;
    logic [5:0]  o_group_index;
    logic [11:0] o_out_x;
    logic [11:0] o_out_y;
    logic [12:0] o_out_w;
    logic [12:0] o_out_h;
    logic        o_group_end;
    logic        o_run_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    // Predictor state
    t_stored_box  frame_boxes[CAPACITY];
    int           frame_count;
    bit [12:0]    img_width;
    bit [12:0]    img_height;
    t_grouped_box grouped_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;

    overlap_box_grouping dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pad one box and clip it to the image
    function automatic t_stored_box pad_and_clip(bit [11:0] x, bit [11:0] y,
                                                 bit [12:0] w, bit [12:0] h);
        t_stored_box b;
        int px, py, pw, ph;
        px = (x > 20) ? int'(x) - 20 : 0;
        py = (y > 50) ? int'(y) - 50 : 0;
        pw = int'(w) + 20;
        ph = int'(h) + 80;
        if (px + pw > int'(img_width)) pw = (int'(img_width) > px) ? int'(img_width) - px : 0;
        if (py + ph > int'(img_height)) ph = (int'(img_height) > py) ? int'(img_height) - py : 0;
        b.x = 12'(px);
        b.y = 12'(py);
        b.w = 14'(pw);
        b.h = 14'(ph);
        return b;
    endfunction

    // Overlap of two boxes, each shrunk by one pixel
    function automatic bit boxes_overlap(t_stored_box a, t_stored_box b);
        int ar, ab, br, bb, lft, tp, rgt, bot;
        ar  = int'(a.x) + int'(a.w) - 1;
        ab  = int'(a.y) + int'(a.h) - 1;
        br  = int'(b.x) + int'(b.w) - 1;
        bb  = int'(b.y) + int'(b.h) - 1;
        lft = (a.x > b.x) ? int'(a.x) : int'(b.x);
        tp  = (a.y > b.y) ? int'(a.y) : int'(b.y);
        rgt = (ar < br) ? ar : br;
        bot = (ab < bb) ? ab : bb;
        return (rgt - lft > 0) && (bot - tp > 0);
    endfunction

    // Append one expected box at the back of the queue
    function automatic void add_expected(t_grouped_box r);
        grouped_q.insert(grouped_q.size(), r);
    endfunction

    // Label the frame and queue its boxes in group order
    task automatic group_frame();
        int lbl[CAPACITY];
        int last, g;
        bit found;
        t_grouped_box r;
        for (int i = 0; i < frame_count; i++) lbl[i] = i;
        for (int i = 0; i < frame_count; i++)
            for (int j = i + 1; j < frame_count; j++)
                if (boxes_overlap(frame_boxes[i], frame_boxes[j])) lbl[j] = lbl[i];
        g = 0;
        for (int l = 0; l < frame_count; l++) begin
            found = 0;
            last = 0;
            for (int i = 0; i < frame_count; i++)
                if (lbl[i] == l) begin
                    found = 1;
                    last = i;
                end
            if (!found) continue;
            for (int i = 0; i < frame_count; i++) begin
                if (lbl[i] != l) continue;
                r.box_index   = 6'(i);
                r.group_index = 6'(g);
                r.x           = frame_boxes[i].x;
                r.y           = frame_boxes[i].y;
                r.w           = frame_boxes[i].w[12:0];
                r.h           = frame_boxes[i].h[12:0];
                r.group_end   = (i == last);
                r.run_end     = 1'b0;
                add_expected(r);
            end
            g++;
        end
        grouped_q[grouped_q.size()-1].run_end = 1'b1;
        frame_count = 0;
    endtask

    // Send one box and update the prediction on transfer
    task automatic send_box(bit [11:0] x, bit [11:0] y, bit [12:0] w, bit [12:0] h,
                            bit fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_box_x     <= x;
        i_box_y     <= y;
        i_box_w     <= w;
        i_box_h     <= h;
        i_final_box <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        if (frame_count < CAPACITY) begin
            frame_boxes[frame_count] = pad_and_clip(x, y, w, h);
            frame_count++;
        end
        if (fin) group_frame();
    endtask

    // Hold until every grouped box is back and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (grouped_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, bit [12:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_IMG_W) img_width = value;
        else img_height = value;
    endtask

    task automatic set_image(bit [12:0] w, bit [12:0] h);
        write_reg(REG_IMG_W, w);
        write_reg(REG_IMG_H, h);
    endtask

    // Random frame: mostly clustered boxes so groups form, some wild ones
    task automatic send_random_frame(int n);
        int cx, cy;
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(7) == 0)
                send_box(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                         13'($urandom_range(4096)), 13'($urandom_range(4096)), k == n - 1);
            else
                send_box(12'((cx + $urandom_range(300)) % 4096),
                         12'((cy + $urandom_range(300)) % 4096),
                         13'($urandom_range(120)), 13'($urandom_range(120)), k == n - 1);
        end
    endtask

    // Extremes of the fields, edge boxes and empty boxes
    task automatic test_directed();
        send_box(12'd0, 12'd0, 13'd0, 13'd0, 1'b1);
        send_box(12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1);
        send_box(12'd20, 12'd50, 13'd10, 13'd10, 1'b0);
        send_box(12'd21, 12'd51, 13'd10, 13'd10, 1'b0);
        send_box(12'd1000, 12'd500, 13'd0, 13'd40, 1'b0);
        send_box(12'd1000, 12'd500, 13'd40, 13'd0, 1'b0);
        send_box(12'd1950, 12'd1200, 13'd50, 13'd50, 1'b1);
        // Boxes that just touch and just overlap after shrinking
        send_box(12'd100, 12'd100, 13'd30, 13'd30, 1'b0);
        send_box(12'd150, 12'd100, 13'd30, 13'd30, 1'b0);
        send_box(12'd148, 12'd100, 13'd30, 13'd30, 1'b0);
        send_box(12'd2000, 12'd900, 13'd30, 13'd30, 1'b0);
        send_box(12'd102, 12'd110, 13'd30, 13'd30, 1'b1);
        send_box(12'd2730, 12'd1365, 13'd2730, 13'd1365, 1'b0);
        send_box(12'd1365, 12'd2730, 13'd5461, 13'd2730, 1'b1);
    endtask

    // Fill the store, then drop boxes; a dropped final box still groups
    task automatic test_capacity();
        send_random_frame(CAPACITY);
        for (int k = 0; k < CAPACITY + 3; k++)
            send_box(12'(10 + k * 7), 12'd300, 13'd20, 13'd20, k == CAPACITY + 2);
    endtask

    task automatic test_random(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            send_random_frame(n);
            sent += n;
        end
    endtask

    // Compare each transfer on the result channel with the oldest expectation
    always @(posedge i_clk) begin
        t_grouped_box e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grouped_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result box %0d", o_box_index);
            end else begin
                e = grouped_q.pop_front();
                if (o_box_index !== e.box_index || o_group_index !== e.group_index ||
                    o_out_x !== e.x || o_out_y !== e.y || o_out_w !== e.w ||
                    o_out_h !== e.h || o_group_end !== e.group_end ||
                    o_run_end !== e.run_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp idx %0d grp %0d %0d,%0d %0dx%0d ge %0b re %0b",
                                 e.box_index, e.group_index, e.x, e.y, e.w, e.h,
                                 e.group_end, e.run_end);
                        $display("         got idx %0d grp %0d %0d,%0d %0dx%0d ge %0b re %0b",
                                 o_box_index, o_group_index, o_out_x, o_out_y,
                                 o_out_w, o_out_h, o_group_end, o_run_end);
                    end
                end
            end
        end
    end

    // Result channel stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        mismatches    = 0;
        frame_count   = 0;
        img_width     = IMG_W_RST;
        img_height    = IMG_H_RST;
        send_idle_pct = 18;
        recv_idle_pct = 64;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_box_x     <= '0;
        i_box_y     <= '0;
        i_box_w     <= '0;
        i_box_h     <= '0;
        i_final_box <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_IMG_W;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_image(13'd4096, 13'd4096);
        test_directed();
        test_capacity();
        set_image(13'd1, 13'd1);
        test_random(20);
        set_image(13'd640, 13'd480);
        test_random(80);

        send_idle_pct = 64;
        recv_idle_pct = 18;
        set_image(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
        test_random(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_image(13'd1920, 13'd1080);
        test_random(80);

        drain();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
